// ===== design/wlb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wlb_pkg;

  localparam int DICT_SIZE = 256;
  localparam int MAX_LEN   = 8;
  localparam int LANES     = 4;
  localparam int ROWS      = DICT_SIZE / LANES;
  localparam int LANE_W    = $clog2(LANES);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int IDX_W     = $clog2(DICT_SIZE);
  localparam int CNT_W     = IDX_W + 1;
  localparam int QDEPTH    = DICT_SIZE + 1;
  localparam int QPTR_W    = $clog2(QDEPTH + 1);
  localparam int STEP_W    = 9;
  localparam int WORD_W    = 64;
  localparam int LEN_W     = 4;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef struct packed {
    logic             clr_vis;
    logic             cmp_en;
    logic [ROW_W-1:0] rd_row;
  } lane_ctl_t;

  typedef struct packed {
    logic              vld;
    logic [LANE_W-1:0] lane;
  } merge_out_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    clamp_len = (len > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len;
  endfunction

  function automatic logic [WORD_W-1:0] mask_word(input logic [WORD_W-1:0] w,
                                                  input logic [LEN_W-1:0]  len);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(len)) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    mask_word = w & m;
  endfunction

  function automatic logic one_byte_diff(input logic [WORD_W-1:0] a,
                                         input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] x;
    logic [7:0]        f;
    x = a ^ b;
    for (int i = 0; i < 8; i++) begin
      f[i] = |x[8*i +: 8];
    end
    one_byte_diff = (f != 8'd0) && ((f & (f - 8'd1)) == 8'd0);
  endfunction

endpackage
`default_nettype wire

// ===== design/word_ladder_bfs_distance_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Word ladder distance engine. Clear and load commands are handled in idle;
// a query runs a breadth-first search and puts one steps_o value out with a
// one-cycle done_o strobe, which the receiver must take as it comes. Four
// lanes each hold a quarter of the dictionary and compare their entries row by
// row against the dequeued word; a merge stage feeds their hits into the queue
// one per cycle. Each dequeued word is fetched (a dictionary word is read back
// from its lane first) and checked against the target, and then all 64 rows are
// read, compared and drained of hits in turn; a query stops at the first check
// when the source is the target. busy is high for the whole query.
module word_ladder_bfs_distance_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic [wlb_pkg::WORD_W-1:0]  word_i,
  input  wire logic [wlb_pkg::LEN_W-1:0]   word_len_i,
  input  wire logic [wlb_pkg::WORD_W-1:0]  target_i,
  input  wire logic [wlb_pkg::LEN_W-1:0]   target_len_i,
  output logic                             done_o,
  output logic [wlb_pkg::STEP_W-1:0]       steps_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SEED, S_DEQ, S_FETCH, S_FETCH2, S_CHECK, S_SCAN_RD, S_SCAN_CMP, S_DRAIN
  } state_e;

  localparam int QE_W = wlb_pkg::CNT_W + wlb_pkg::STEP_W;
  localparam logic [wlb_pkg::CNT_W-1:0] SRC_MARK = wlb_pkg::CNT_W'(wlb_pkg::DICT_SIZE);

  state_e                         state_q;
  logic [wlb_pkg::CNT_W-1:0]      count_q;
  logic [wlb_pkg::QPTR_W-1:0]     head_q, tail_q;
  logic [wlb_pkg::ROW_W-1:0]      row_q;
  logic [wlb_pkg::LANE_W-1:0]     lsel_q;
  logic [wlb_pkg::WORD_W-1:0]     src_q, tgt_q, cur_q;
  logic [wlb_pkg::LEN_W-1:0]      slen_q, tlen_q, clen_q;
  logic [wlb_pkg::STEP_W-1:0]     cstep_q;

  logic [QE_W-1:0]                qmem [wlb_pkg::QDEPTH];
  logic [QE_W-1:0]                qrd_q;
  logic                           qwr_en;
  logic [wlb_pkg::QPTR_W-1:0]     qwr_addr;
  logic [QE_W-1:0]                qwr_data;

  wlb_pkg::lane_ctl_t             ctl;
  wlb_pkg::merge_out_t            mo;
  logic [wlb_pkg::LANES-1:0]      hits, wr_en, in_range;
  logic [wlb_pkg::WORD_W-1:0]     rd_word [wlb_pkg::LANES];
  logic [wlb_pkg::LEN_W-1:0]      rd_len  [wlb_pkg::LANES];
  logic [wlb_pkg::LEN_W-1:0]      in_len;
  logic [wlb_pkg::WORD_W-1:0]     in_word;
  logic                           accept;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign in_len  = wlb_pkg::clamp_len(word_len_i);
  assign in_word = wlb_pkg::mask_word(word_i, in_len);

  always_comb begin
    ctl.clr_vis = accept && (cmd_i == wlb_pkg::CMD_QUERY);
    ctl.cmp_en  = (state_q == S_SCAN_CMP);
    ctl.rd_row  = row_q;
    if (state_q == S_FETCH) begin
      ctl.rd_row = qrd_q[wlb_pkg::STEP_W + wlb_pkg::LANE_W +: wlb_pkg::ROW_W];
    end
    for (int l = 0; l < wlb_pkg::LANES; l++) begin
      wr_en[l] = accept && (cmd_i == wlb_pkg::CMD_LOAD) &&
                 (count_q < wlb_pkg::CNT_W'(wlb_pkg::DICT_SIZE)) &&
                 (count_q[wlb_pkg::LANE_W-1:0] == wlb_pkg::LANE_W'(l));
      in_range[l] = {1'b0, row_q, wlb_pkg::LANE_W'(l)} < count_q;
    end
  end

  for (genvar g = 0; g < wlb_pkg::LANES; g++) begin : g_lane
    wlb_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (wr_en[g]),
      .wr_row_i   (count_q[wlb_pkg::LANE_W +: wlb_pkg::ROW_W]),
      .wr_word_i  (in_word),
      .wr_len_i   (in_len),
      .ctl_i      (ctl),
      .in_range_i (in_range[g]),
      .cur_word_i (cur_q),
      .cur_len_i  (clen_q),
      .rd_word_o  (rd_word[g]),
      .rd_len_o   (rd_len[g]),
      .hit_o      (hits[g])
    );
  end

  wlb_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (state_q == S_SCAN_CMP),
    .hits_i (hits),
    .out_o  (mo)
  );

  always_comb begin
    qwr_en   = 1'b0;
    qwr_addr = tail_q;
    qwr_data = {SRC_MARK, wlb_pkg::STEP_W'(0)};
    if (state_q == S_SEED) begin
      qwr_en = 1'b1;
    end else if (state_q == S_DRAIN && mo.vld) begin
      qwr_en   = 1'b1;
      qwr_data = {1'b0, row_q, mo.lane, cstep_q + wlb_pkg::STEP_W'(1)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (qwr_en) begin
      qmem[qwr_addr] <= qwr_data;
    end
    qrd_q <= qmem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      row_q   <= '0;
      lsel_q  <= '0;
      done_o  <= 1'b0;
      steps_o <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd_i)
              wlb_pkg::CMD_CLEAR: count_q <= '0;
              wlb_pkg::CMD_LOAD: begin
                if (count_q < wlb_pkg::CNT_W'(wlb_pkg::DICT_SIZE)) begin
                  count_q <= count_q + wlb_pkg::CNT_W'(1);
                end
              end
              wlb_pkg::CMD_QUERY: begin
                head_q  <= '0;
                tail_q  <= '0;
                state_q <= S_SEED;
              end
              default: ;
            endcase
          end
        end
        S_SEED: begin
          tail_q  <= tail_q + wlb_pkg::QPTR_W'(1);
          state_q <= S_DEQ;
        end
        S_DEQ: begin
          if (head_q == tail_q) begin
            done_o  <= 1'b1;
            steps_o <= '0;
            state_q <= S_IDLE;
          end else begin
            head_q  <= head_q + wlb_pkg::QPTR_W'(1);
            state_q <= S_FETCH;
          end
        end
        S_FETCH: begin
          lsel_q  <= qrd_q[wlb_pkg::STEP_W +: wlb_pkg::LANE_W];
          state_q <= (qrd_q[QE_W-1 -: wlb_pkg::CNT_W] == SRC_MARK) ? S_CHECK : S_FETCH2;
        end
        S_FETCH2: state_q <= S_CHECK;
        S_CHECK: begin
          if (clen_q == tlen_q && cur_q == tgt_q) begin
            done_o  <= 1'b1;
            steps_o <= cstep_q;
            state_q <= S_IDLE;
          end else begin
            row_q   <= '0;
            state_q <= S_SCAN_RD;
          end
        end
        S_SCAN_RD:  state_q <= S_SCAN_CMP;
        S_SCAN_CMP: state_q <= S_DRAIN;
        S_DRAIN: begin
          if (mo.vld) begin
            tail_q <= tail_q + wlb_pkg::QPTR_W'(1);
          end else if (row_q == wlb_pkg::ROW_W'(wlb_pkg::ROWS - 1)) begin
            state_q <= S_DEQ;
          end else begin
            row_q   <= row_q + wlb_pkg::ROW_W'(1);
            state_q <= S_SCAN_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == wlb_pkg::CMD_QUERY) begin
      src_q  <= in_word;
      slen_q <= in_len;
      tlen_q <= wlb_pkg::clamp_len(target_len_i);
      tgt_q  <= wlb_pkg::mask_word(target_i, wlb_pkg::clamp_len(target_len_i));
    end
    if (state_q == S_FETCH) begin
      cstep_q <= qrd_q[wlb_pkg::STEP_W-1:0];
      if (qrd_q[QE_W-1 -: wlb_pkg::CNT_W] == SRC_MARK) begin
        cur_q  <= src_q;
        clen_q <= slen_q;
      end
    end else if (state_q == S_FETCH2) begin
      cur_q  <= rd_word[lsel_q];
      clen_q <= rd_len[lsel_q];
    end
  end

  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q) else $error("queue head passed tail");
  a_tail_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= wlb_pkg::QPTR_W'(wlb_pkg::QDEPTH)) else $error("queue overflow");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= wlb_pkg::CNT_W'(wlb_pkg::DICT_SIZE)) else $error("dictionary overflow");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

endmodule
`default_nettype wire

// ===== design/wlb_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wlb_lane (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_en_i,
  input  wire logic [wlb_pkg::ROW_W-1:0]   wr_row_i,
  input  wire logic [wlb_pkg::WORD_W-1:0]  wr_word_i,
  input  wire logic [wlb_pkg::LEN_W-1:0]   wr_len_i,
  input  wire wlb_pkg::lane_ctl_t          ctl_i,
  input  wire logic                        in_range_i,
  input  wire logic [wlb_pkg::WORD_W-1:0]  cur_word_i,
  input  wire logic [wlb_pkg::LEN_W-1:0]   cur_len_i,
  output logic [wlb_pkg::WORD_W-1:0]       rd_word_o,
  output logic [wlb_pkg::LEN_W-1:0]        rd_len_o,
  output logic                             hit_o
);

  logic [wlb_pkg::WORD_W-1:0] mem_word [wlb_pkg::ROWS];
  logic [wlb_pkg::LEN_W-1:0]  mem_len  [wlb_pkg::ROWS];
  logic [wlb_pkg::ROWS-1:0]   vis_q;
  logic [wlb_pkg::ROW_W-1:0]  row_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_word[wr_row_i] <= wr_word_i;
      mem_len[wr_row_i]  <= wr_len_i;
    end
    rd_word_o <= mem_word[ctl_i.rd_row];
    rd_len_o  <= mem_len[ctl_i.rd_row];
  end

  assign hit_o = ctl_i.cmp_en && in_range_i && !vis_q[row_q] &&
                 (rd_len_o == cur_len_i) && wlb_pkg::one_byte_diff(rd_word_o, cur_word_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q <= '0;
      row_q <= '0;
    end else begin
      row_q <= ctl_i.rd_row;
      if (ctl_i.clr_vis) begin
        vis_q <= '0;
      end else if (hit_o) begin
        vis_q[row_q] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/wlb_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wlb_merge (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       load_i,
  input  wire logic [wlb_pkg::LANES-1:0]  hits_i,
  output wlb_pkg::merge_out_t             out_o
);

  logic [wlb_pkg::LANES-1:0] pend_q, pend_d;

  always_comb begin
    out_o.vld  = |pend_q;
    out_o.lane = '0;
    for (int i = wlb_pkg::LANES - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        out_o.lane = wlb_pkg::LANE_W'(i);
      end
    end
    pend_d = pend_q;
    if (load_i) begin
      pend_d = hits_i;
    end else if (out_o.vld) begin
      pend_d[out_o.lane] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

endmodule
`default_nettype wire
